// ===== rtl/rpt_pkg.sv =====
// rpt_pkg: shared types, constants and helpers for the rigid pose transform unit.
// No dependencies; used by rtl/rigid_pose_transform_unit.sv.

package rpt_pkg;

    localparam int DW = 32;  // word width of every field and stored entry
    localparam int FB = 16;  // fraction bits

    localparam logic [DW-1:0] ONE = DW'(1) << FB;

    typedef enum logic [2:0] {
        A_RESET,
        A_SETPOS,
        A_FRAME_A,
        A_FRAME_B,
        A_TO_WORLD,
        A_TO_LOCAL,
        A_ROTATE,
        A_UNROTATE
    } t_act;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_FLUSH,
        S_XRES,
        S_DONE,
        S_NABS,
        S_NSHIFT,
        S_NROOT0,
        S_NROOT,
        S_NDIV0,
        S_NDIV,
        S_FU,
        S_FDOT,
        S_FPERP,
        S_FQ,
        S_FCROSS
    } t_state;

    typedef enum logic [2:0] {
        J_XFORM,
        J_SQ,
        J_DOT,
        J_PERP,
        J_CROSS
    } t_job;

    function automatic logic signed [DW-1:0] sat(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = $signed({{(66-DW+1){1'b0}}, {(DW-1){1'b1}}});
        lo = -hi - 66'sd1;
        if (x > hi) begin
            sat = hi[DW-1:0];
        end else if (x < lo) begin
            sat = lo[DW-1:0];
        end else begin
            sat = x[DW-1:0];
        end
    endfunction

endpackage

// ===== rtl/rigid_pose_transform_unit.sv =====
// rigid_pose_transform_unit: pose store with Gram-Schmidt frame build and point transforms.
// One shared 35x33 multiplier with accumulator, a bit-serial square root and divider.
// Depends on rtl/rpt_pkg.sv.
// Transforms make nine passes through the shared multiply-accumulate (eighteen for world to
// local). Frame build makes two normalizations, each a 32-step square root and three 17-step
// divisions. One transfer in flight; a result waits in the output register.
// Reset (synchronous, active low) sets identity orientation and zero position.

module rigid_pose_transform_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [191:0] i_s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [2:0]   i_s_axis_tuser,   // action
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata    // out_x, out_y, out_z
);

    localparam int DW = rpt_pkg::DW;
    localparam int FB = rpt_pkg::FB;

    rpt_pkg::t_state r_state, n_state, r_mret, n_mret, r_nret, n_nret;
    rpt_pkg::t_job   r_job, n_job;
    rpt_pkg::t_act   r_act, n_act;

    logic signed [DW-1:0] r_a [3], n_a [3];
    logic signed [DW-1:0] r_b [3], n_b [3];
    logic signed [DW-1:0] r_rot [9], n_rot [9];
    logic signed [DW-1:0] r_pos [3], n_pos [3];
    logic signed [DW-1:0] r_res [3], n_res [3];
    logic signed [DW-1:0] r_out [3], n_out [3];
    logic signed [34:0]   r_w [3], n_w [3];
    logic [34:0]          r_m [3], n_m [3];
    logic [2:0]           r_neg, n_neg;
    logic signed [17:0]   r_u [3], n_u [3];
    logic signed [17:0]   r_nv [3], n_nv [3];
    logic signed [34:0]   r_dot, n_dot;
    logic [1:0]           r_c, n_c;
    logic [2:0]           r_k, n_k, r_kl, n_kl;
    logic [4:0]           r_cnt, n_cnt;
    logic [63:0]          r_rn, n_rn, r_rr, n_rr, r_bit, n_bit;
    logic [47:0]          r_rem, n_rem, r_dvs, n_dvs;
    logic [16:0]          r_quo, n_quo;
    logic signed [65:0]   r_acc, n_acc;
    logic                 r_ovld, n_ovld;

    logic signed [67:0]   r_prod;
    logic                 r_pv, r_pclr, r_psub, r_praw;
    logic signed [DW-1:0] r_pbase;

    logic                 issue;
    logic signed [34:0]   op_a;
    logic signed [32:0]   op_b;
    logic                 iss_sub, iss_raw;
    logic signed [DW-1:0] iss_base;
    logic signed [65:0]   term;
    logic [63:0]          rt;
    logic                 ge;
    logic [16:0]          quo_n;
    logic signed [17:0]   qs;
    logic [1:0]           k3, c1, c2;
    logic [3:0]           ri;
    logic                 ord_b;
    logic signed [17:0]   r0v [3], r2v [3];

    assign o_s_axis_tready = (r_state == rpt_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};

    assign ord_b = (r_act == rpt_pkg::A_FRAME_B);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r0v[i] = ord_b ? r_nv[i] : r_u[i];
            r2v[i] = ord_b ? r_u[i] : r_nv[i];
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        k3       = (r_k >= 3'd3) ? 2'(r_k - 3'd3) : r_k[1:0];
        c1       = (r_c == 2'd2) ? 2'd0 : 2'(r_c + 2'd1);
        c2       = (r_c == 2'd0) ? 2'd2 : 2'(r_c - 2'd1);
        ri       = 4'd0;
        op_a     = '0;
        op_b     = '0;
        iss_sub  = 1'b0;
        iss_raw  = 1'b0;
        iss_base = '0;
        case (r_job)
            rpt_pkg::J_XFORM: begin
                if (r_act == rpt_pkg::A_TO_WORLD || r_act == rpt_pkg::A_ROTATE) begin
                    ri = 4'(k3) * 4'd3 + 4'(r_c);
                end else begin
                    ri = 4'(r_c) * 4'd3 + 4'(k3);
                end
                op_a    = 35'(r_rot[ri]);
                op_b    = (r_k >= 3'd3) ? 33'(r_pos[k3]) : 33'(r_a[k3]);
                iss_sub = (r_k >= 3'd3);
                if (r_act == rpt_pkg::A_TO_WORLD) begin
                    iss_base = r_pos[r_c];
                end
            end
            rpt_pkg::J_SQ: begin
                op_a    = $signed({4'b0, r_m[k3][30:0]});
                op_b    = $signed({2'b0, r_m[k3][30:0]});
                iss_raw = 1'b1;
            end
            rpt_pkg::J_DOT: begin
                op_a = 35'(r_u[k3]);
                op_b = 33'(r_b[k3]);
            end
            rpt_pkg::J_PERP: begin
                op_a     = r_dot;
                op_b     = 33'(r_u[r_c]);
                iss_sub  = 1'b1;
                iss_base = r_b[r_c];
            end
            rpt_pkg::J_CROSS: begin
                if (r_k == 3'd0) begin
                    op_a = 35'(r2v[c1]);
                    op_b = 33'(r0v[c2]);
                end else begin
                    op_a    = 35'(r2v[c2]);
                    op_b    = 33'(r0v[c1]);
                    iss_sub = 1'b1;
                end
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_mret  = r_mret;
        n_nret  = r_nret;
        n_job   = r_job;
        n_act   = r_act;
        n_a     = r_a;
        n_b     = r_b;
        n_rot   = r_rot;
        n_pos   = r_pos;
        n_res   = r_res;
        n_out   = r_out;
        n_w     = r_w;
        n_m     = r_m;
        n_neg   = r_neg;
        n_u     = r_u;
        n_nv    = r_nv;
        n_dot   = r_dot;
        n_c     = r_c;
        n_k     = r_k;
        n_kl    = r_kl;
        n_cnt   = r_cnt;
        n_rn    = r_rn;
        n_rr    = r_rr;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        n_acc   = r_acc;
        n_ovld  = r_ovld;
        issue   = 1'b0;

        term  = r_praw ? r_prod[65:0] : 66'(r_prod >>> FB);
        rt    = r_rr + r_bit;
        ge    = (r_rem >= r_dvs);
        quo_n = {r_quo[15:0], ge};
        qs    = $signed({1'b0, quo_n});

        if (r_pv) begin
            n_acc = (r_pclr ? 66'(r_pbase) : r_acc) + (r_psub ? -term : term);
        end

        if (r_ovld && i_m_axis_tready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            rpt_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_act = rpt_pkg::t_act'(i_s_axis_tuser);
                    for (int i = 0; i < 3; i++) begin
                        n_a[i] = $signed(i_s_axis_tdata[DW*i +: DW]);
                        n_b[i] = $signed(i_s_axis_tdata[DW*(i+3) +: DW]);
                        n_w[i] = 35'($signed(i_s_axis_tdata[DW*i +: DW]));
                    end
                    n_c = 2'd0;
                    case (rpt_pkg::t_act'(i_s_axis_tuser))
                        rpt_pkg::A_RESET: begin
                            for (int i = 0; i < 9; i++) begin
                                n_rot[i] = (i % 4 == 0) ? $signed(rpt_pkg::ONE) : '0;
                            end
                            for (int i = 0; i < 3; i++) begin
                                n_pos[i] = '0;
                            end
                        end
                        rpt_pkg::A_SETPOS: begin
                            for (int i = 0; i < 3; i++) begin
                                n_pos[i] = $signed(i_s_axis_tdata[DW*i +: DW]);
                            end
                        end
                        rpt_pkg::A_FRAME_A, rpt_pkg::A_FRAME_B: begin
                            n_nret  = rpt_pkg::S_FU;
                            n_state = rpt_pkg::S_NABS;
                        end
                        default: begin
                            n_job   = rpt_pkg::J_XFORM;
                            n_k     = 3'd0;
                            n_kl    = (rpt_pkg::t_act'(i_s_axis_tuser) == rpt_pkg::A_TO_LOCAL)
                                      ? 3'd5 : 3'd2;
                            n_mret  = rpt_pkg::S_XRES;
                            n_state = rpt_pkg::S_MAC;
                        end
                    endcase
                end
            end
            rpt_pkg::S_MAC: begin
                issue = 1'b1;
                if (r_k == r_kl) begin
                    n_state = rpt_pkg::S_FLUSH;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            rpt_pkg::S_FLUSH: begin
                n_state = r_mret;
            end
            rpt_pkg::S_XRES: begin
                n_res[r_c] = rpt_pkg::sat(r_acc);
                if (r_c == 2'd2) begin
                    n_state = rpt_pkg::S_DONE;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_k     = 3'd0;
                    n_state = rpt_pkg::S_MAC;
                end
            end
            rpt_pkg::S_DONE: begin
                if (!r_ovld || i_m_axis_tready) begin
                    n_out   = r_res;
                    n_ovld  = 1'b1;
                    n_state = rpt_pkg::S_IDLE;
                end
            end
            rpt_pkg::S_NABS: begin
                for (int i = 0; i < 3; i++) begin
                    n_neg[i] = r_w[i][34];
                    n_m[i]   = r_w[i][34] ? 35'(-r_w[i]) : 35'(r_w[i]);
                end
                n_state = rpt_pkg::S_NSHIFT;
            end
            rpt_pkg::S_NSHIFT: begin
                if ((r_m[0][34:31] | r_m[1][34:31] | r_m[2][34:31]) != 4'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_m[i] = r_m[i] >> 1;
                    end
                end else begin
                    n_job   = rpt_pkg::J_SQ;
                    n_k     = 3'd0;
                    n_kl    = 3'd2;
                    n_mret  = rpt_pkg::S_NROOT0;
                    n_state = rpt_pkg::S_MAC;
                end
            end
            rpt_pkg::S_NROOT0: begin
                n_rn    = r_acc[63:0];
                n_rr    = '0;
                n_bit   = 64'd1 << 62;
                n_cnt   = 5'd31;
                n_state = rpt_pkg::S_NROOT;
            end
            rpt_pkg::S_NROOT: begin
                if (r_rn >= rt) begin
                    n_rn = r_rn - rt;
                    n_rr = (r_rr >> 1) + r_bit;
                end else begin
                    n_rr = r_rr >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_c     = 2'd0;
                    n_state = rpt_pkg::S_NDIV0;
                end
            end
            rpt_pkg::S_NDIV0: begin
                n_rem   = {1'b0, r_m[r_c][30:0], 16'b0};
                n_dvs   = {r_rr[31:0], 16'b0};
                n_quo   = '0;
                n_cnt   = 5'd16;
                n_state = rpt_pkg::S_NDIV;
            end
            rpt_pkg::S_NDIV: begin
                if (ge) begin
                    n_rem = r_rem - r_dvs;
                end
                n_dvs = r_dvs >> 1;
                n_quo = quo_n;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    if (r_rr == 64'd0) begin
                        n_nv[r_c] = '0;
                    end else begin
                        n_nv[r_c] = r_neg[r_c] ? -qs : qs;
                    end
                    if (r_c == 2'd2) begin
                        n_state = r_nret;
                    end else begin
                        n_c     = r_c + 2'd1;
                        n_state = rpt_pkg::S_NDIV0;
                    end
                end
            end
            rpt_pkg::S_FU: begin
                n_u     = r_nv;
                n_job   = rpt_pkg::J_DOT;
                n_k     = 3'd0;
                n_kl    = 3'd2;
                n_mret  = rpt_pkg::S_FDOT;
                n_state = rpt_pkg::S_MAC;
            end
            rpt_pkg::S_FDOT: begin
                n_dot   = r_acc[34:0];
                n_c     = 2'd0;
                n_job   = rpt_pkg::J_PERP;
                n_k     = 3'd0;
                n_kl    = 3'd0;
                n_mret  = rpt_pkg::S_FPERP;
                n_state = rpt_pkg::S_MAC;
            end
            rpt_pkg::S_FPERP: begin
                n_w[r_c] = r_acc[34:0];
                if (r_c == 2'd2) begin
                    n_nret  = rpt_pkg::S_FQ;
                    n_state = rpt_pkg::S_NABS;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_k     = 3'd0;
                    n_state = rpt_pkg::S_MAC;
                end
            end
            rpt_pkg::S_FQ: begin
                for (int i = 0; i < 3; i++) begin
                    n_rot[i]     = DW'(r0v[i]);
                    n_rot[6 + i] = DW'(r2v[i]);
                end
                n_c     = 2'd0;
                n_job   = rpt_pkg::J_CROSS;
                n_k     = 3'd0;
                n_kl    = 3'd1;
                n_mret  = rpt_pkg::S_FCROSS;
                n_state = rpt_pkg::S_MAC;
            end
            rpt_pkg::S_FCROSS: begin
                n_rot[3 + r_c] = rpt_pkg::sat(r_acc);
                if (r_c == 2'd2) begin
                    n_state = rpt_pkg::S_IDLE;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_k     = 3'd0;
                    n_state = rpt_pkg::S_MAC;
                end
            end
            default: begin
                n_state = rpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpt_pkg::S_IDLE;
            r_ovld  <= 1'b0;
            r_pv    <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_rot[i] <= (i % 4 == 0) ? $signed(rpt_pkg::ONE) : '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_pv    <= issue;
            r_rot   <= n_rot;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mret  <= n_mret;
        r_nret  <= n_nret;
        r_job   <= n_job;
        r_act   <= n_act;
        r_a     <= n_a;
        r_b     <= n_b;
        r_res   <= n_res;
        r_out   <= n_out;
        r_w     <= n_w;
        r_m     <= n_m;
        r_neg   <= n_neg;
        r_u     <= n_u;
        r_nv    <= n_nv;
        r_dot   <= n_dot;
        r_c     <= n_c;
        r_k     <= n_k;
        r_kl    <= n_kl;
        r_cnt   <= n_cnt;
        r_rn    <= n_rn;
        r_rr    <= n_rr;
        r_bit   <= n_bit;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_quo   <= n_quo;
        r_acc   <= n_acc;
        r_prod  <= op_a * op_b;
        r_pclr  <= (r_k == 3'd0);
        r_psub  <= iss_sub;
        r_praw  <= iss_raw;
        r_pbase <= iss_base;
    end

endmodule
